FILE: src/i2csrf_pkg.sv
// shared constants, phase codes and controller/datapath structs
// for the i2c slave register file; no dependencies
`timescale 1ns / 1ps

package i2csrf_pkg;

  // register bank geometry
  localparam int RegDepth = 16;
  localparam int PtrW     = (RegDepth > 1) ? $clog2(RegDepth) : 1;

  // bus phase codes as seen on the phase output
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ACK_RX   = 3'd1;
  localparam logic [2:0] PH_BYTE_RX  = 3'd2;
  localparam logic [2:0] PH_ACK_TX   = 3'd3;
  localparam logic [2:0] PH_WAIT_ACK = 3'd4;
  localparam logic [2:0] PH_BYTE_TX  = 3'd5;

  // input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_SHIFT = 1'b1;

  // configuration register indexes
  localparam logic REG_SLAVE_ADDRESS = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic ptr_load;   // capture register pointer from bus byte
    logic val_load;   // capture first write data byte
    logic chk_load;   // capture check byte
    logic do_check;   // evaluate checked write on this transaction
    logic tx_load;    // load register byte and advance the pointer
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic addr_match; // bus byte bits 7..1 equal the slave address
    logic check_ok;   // checksum of the held pair matches
  } dp_status_t;

  // per-transaction result flags from the controller
  typedef struct packed {
    logic [2:0] phase;
    logic       listening;
    logic       drive_ack;
    logic       tx_load;
    logic       reg_written;
    logic       check_failed;
  } ctrl_result_t;

endpackage

FILE: src/i2csrf_datapath.sv
// datapath: register pointer, write capture, checksum, register bank
// depends on i2csrf_pkg
`timescale 1ns / 1ps

module i2csrf_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             bus_byte_i,
  input  logic [6:0]             slave_address_i,
  input  i2csrf_pkg::dp_cmd_t    cmd_i,
  output i2csrf_pkg::dp_status_t status_o,
  output logic [7:0]             tx_byte_o
);
  import i2csrf_pkg::*;

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [7:0]      val_q, val_d;
  logic [7:0]      chk_q, chk_d;
  logic [7:0]      bank_q [RegDepth];
  logic [7:0]      chk_sel;
  logic [7:0]      chk_calc;
  logic            store;

  // address compare
  assign status_o.addr_match = (bus_byte_i[7:1] == slave_address_i);

  // check byte comes straight from the bus when it arrives this transaction
  assign chk_sel  = cmd_i.chk_load ? bus_byte_i : chk_q;
  assign chk_calc = (~8'(ptr_q)) ^ val_q;
  assign status_o.check_ok = (chk_calc == chk_sel);

  assign store = accept_i && cmd_i.do_check && status_o.check_ok;

  // transmit byte, zero when nothing is loaded
  assign tx_byte_o = cmd_i.tx_load ? bank_q[ptr_q] : 8'h00;

  // next pointer and write capture values
  always_comb begin
    ptr_d = ptr_q;
    val_d = val_q;
    chk_d = chk_q;
    if (accept_i) begin
      if (cmd_i.ptr_load) begin
        if ({1'b0, bus_byte_i} < 9'(RegDepth)) begin
          ptr_d = bus_byte_i[PtrW-1:0];
        end else begin
          ptr_d = '0;
        end
        val_d = 8'h00;
        chk_d = 8'h00;
      end
      if (cmd_i.val_load) begin
        val_d = bus_byte_i;
      end
      if (cmd_i.chk_load) begin
        chk_d = bus_byte_i;
      end
      if (cmd_i.tx_load) begin
        if (ptr_q == PtrW'(RegDepth - 1)) begin
          ptr_d = '0;
        end else begin
          ptr_d = ptr_q + PtrW'(1);
        end
      end
    end
  end

  // pointer and write capture registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      val_q <= 8'h00;
      chk_q <= 8'h00;
    end else begin
      ptr_q <= ptr_d;
      val_q <= val_d;
      chk_q <= chk_d;
    end
  end

  // register bank, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegDepth; i++) begin
        bank_q[i] <= 8'h00;
      end
    end else if (store) begin
      bank_q[ptr_q] <= val_q;
    end
  end

endmodule

FILE: src/i2csrf_ctrl.sv
// controller: bus phase state machine, follow flag, write byte counter
// depends on i2csrf_pkg
`timescale 1ns / 1ps

module i2csrf_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     func_i,
  input  logic [7:0]               bus_byte_i,
  input  i2csrf_pkg::dp_status_t   status_i,
  output i2csrf_pkg::dp_cmd_t      cmd_o,
  output i2csrf_pkg::ctrl_result_t result_o
);
  import i2csrf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ACK_RX   = 6'b000010,
    ST_BYTE_RX  = 6'b000100,
    ST_ACK_TX   = 6'b001000,
    ST_WAIT_ACK = 6'b010000,
    ST_BYTE_TX  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic       follow_q, follow_d;
  logic       captured_q, captured_d;
  logic [1:0] wcnt_q, wcnt_d;
  logic       drive;

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    follow_d   = follow_q;
    captured_d = captured_q;
    wcnt_d     = wcnt_q;
    drive      = 1'b0;
    cmd_o      = '0;
    if (accept_i) begin
      if (func_i == FUNC_START) begin
        state_d  = ST_IDLE;
        follow_d = 1'b1;
      end else if (follow_q) begin
        case (state_q)
          ST_IDLE: begin
            if (!status_i.addr_match) begin
              follow_d = 1'b0;
            end else begin
              drive      = 1'b1;
              captured_d = 1'b0;
              state_d    = bus_byte_i[0] ? ST_ACK_TX : ST_ACK_RX;
            end
          end
          ST_ACK_RX: begin
            state_d = ST_BYTE_RX;
          end
          ST_BYTE_RX: begin
            if (!captured_q) begin
              cmd_o.ptr_load = 1'b1;
              captured_d     = 1'b1;
              wcnt_d         = 2'd0;
            end else if (wcnt_q == 2'd0) begin
              cmd_o.val_load = 1'b1;
              wcnt_d         = 2'd1;
            end else if (wcnt_q == 2'd1) begin
              cmd_o.chk_load = 1'b1;
              cmd_o.do_check = 1'b1;
              wcnt_d         = 2'd2;
            end else begin
              // extra bytes are dropped, held pair checked again
              cmd_o.do_check = 1'b1;
            end
            drive   = 1'b1;
            state_d = ST_ACK_RX;
          end
          ST_ACK_TX: begin
            cmd_o.tx_load = 1'b1;
            state_d       = ST_BYTE_TX;
          end
          ST_WAIT_ACK: begin
            if (bus_byte_i[0]) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.tx_load = 1'b1;
              state_d       = ST_BYTE_TX;
            end
          end
          ST_BYTE_TX: begin
            state_d = ST_WAIT_ACK;
          end
          default: begin
            state_d = state_q;
          end
        endcase
      end
    end
  end

  // result flags for this transaction
  always_comb begin
    case (state_d)
      ST_IDLE:     result_o.phase = PH_IDLE;
      ST_ACK_RX:   result_o.phase = PH_ACK_RX;
      ST_BYTE_RX:  result_o.phase = PH_BYTE_RX;
      ST_ACK_TX:   result_o.phase = PH_ACK_TX;
      ST_WAIT_ACK: result_o.phase = PH_WAIT_ACK;
      ST_BYTE_TX:  result_o.phase = PH_BYTE_TX;
      default:     result_o.phase = PH_IDLE;
    endcase
    result_o.listening    = follow_d;
    result_o.drive_ack    = drive;
    result_o.tx_load      = cmd_o.tx_load;
    result_o.reg_written  = cmd_o.do_check && status_i.check_ok;
    result_o.check_failed = cmd_o.do_check && !status_i.check_ok;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      follow_q   <= 1'b0;
      captured_q <= 1'b0;
      wcnt_q     <= 2'd0;
    end else begin
      state_q    <= state_d;
      follow_q   <= follow_d;
      captured_q <= captured_d;
      wcnt_q     <= wcnt_d;
    end
  end

`ifndef ASSERT_OFF
  // write counter never passes two
  assert property (@(posedge clk_i) disable iff (!rst_ni) wcnt_q != 2'd3)
    else $error("write byte counter out of range");

  // a check only happens once the pointer is captured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_check |-> captured_q && state_q == ST_BYTE_RX)
    else $error("write check before pointer capture");

  // nothing happens on a shift while not following
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && func_i && !follow_q |=> $stable(state_q) && !follow_q)
    else $error("state moved while not following");
`endif

endmodule

FILE: src/i2c_slave_register_file.sv
// top level of the i2c slave register file: apb slave address register,
// output register, controller and datapath; depends on i2csrf_pkg
`timescale 1ns / 1ps

// Byte-level i2c slave with a checked-write register bank.
// Input channel (in_valid_i / in_stall_o) carries one bus event per
// transaction: func_i = 0 for a start condition, 1 for a completed byte or
// ack shift, with the shifted byte on bus_byte_i. Every accepted event
// gives exactly one result transaction on the output channel
// (out_valid_o / out_stall_i): phase, listening, drive_ack, tx_load,
// tx_byte, reg_written and check_failed, all taken after the event.
// The result is registered: it is in the output register at the edge
// after acceptance. Throughput is one event per cycle unless the output
// stalls; the controller state machine and the combinational register
// bank read set this figure. When the receiver stalls, the held result
// stays put and the input stalls too until the result is taken.
// The slave address is written over the apb port at byte address 0.
// Reset clears the phase, the follow flag, the pointer, the register bank
// and the slave address; the block accepts events right after reset.

module i2c_slave_register_file (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  bus_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  phase_o,
  output logic        listening_o,
  output logic        drive_ack_o,
  output logic        tx_load_o,
  output logic [7:0]  tx_byte_o,
  output logic        reg_written_o,
  output logic        check_failed_o
);
  import i2csrf_pkg::*;

  logic         accept;
  logic [6:0]   slave_addr_q;
  logic         out_valid_q;
  dp_cmd_t      cmd;
  dp_status_t   status;
  ctrl_result_t result;
  ctrl_result_t result_q;
  logic [7:0]   tx_byte;
  logic [7:0]   tx_byte_q;

  // apb register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {25'd0, slave_addr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 7'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_SLAVE_ADDRESS) begin
      slave_addr_q <= pwdata[6:0];
    end
  end

  // input handshake: take a new event unless a held result is stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  i2csrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .bus_byte_i (bus_byte_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .result_o   (result)
  );

  i2csrf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .bus_byte_i      (bus_byte_i),
    .slave_address_i (slave_addr_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .tx_byte_o       (tx_byte)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q  <= result;
      tx_byte_q <= tx_byte;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phase_o        = result_q.phase;
  assign listening_o    = result_q.listening;
  assign drive_ack_o    = result_q.drive_ack;
  assign tx_load_o      = result_q.tx_load;
  assign tx_byte_o      = tx_byte_q;
  assign reg_written_o  = result_q.reg_written;
  assign check_failed_o = result_q.check_failed;

`ifndef ASSERT_OFF
  // the transmit byte is zero unless a register byte was loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_load_o |-> tx_byte_o == 8'h00)
    else $error("tx byte set without tx load");

  // a checked write either stores or fails, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_written_o && check_failed_o))
    else $error("write both stored and failed");

  // a slave that stopped following does not drive the bus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !listening_o |-> !drive_ack_o && !tx_load_o && phase_o == PH_IDLE)
    else $error("bus activity while not listening");
`endif

endmodule
